[rtl/sx7u_pkg.sv]
`timescale 1ns / 1ps

package sx7u_pkg;

    localparam int GROUP_LEN   = 7;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    localparam logic [COUNT_W-1:0] CAP_RESET = 16'hFFFF;

    // Bit positions of the result fields in m_tdata
    localparam int M_BYTE_LSB  = 0;
    localparam int M_STAT_LSB  = 8;
    localparam int M_STAT_MSB  = 10;
    localparam int M_CNT_LSB   = 11;
    localparam int M_CNT_MSB   = 26;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HIGH_BIT = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_BAD_MSB  = 3'd3,
        ST_NO_ROOM  = 3'd4
    } status_t;

endpackage

[rtl/sysex_7bit_unpack_checker_unit.sv]
`timescale 1ns / 1ps

// A word that closes a group passes through the input register, then the emit buffer.
// Throughput: one input word per cycle; a closing word loads up to 8 result words
//   (7 data + status) into the emit buffer, which drains one per cycle while m_tready
//   is high; a later closing word waits until that buffer is empty or taking its final word.
// Reset: clears message state, input register and emit buffer; out_capacity
//   returns to 65535. The group buffer holds no reset value.
module sysex_7bit_unpack_checker_unit
    import sx7u_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [COUNT_W-1:0]   cfg_wr_data,   // out_capacity
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // [7:0] in_byte
    input  logic                 s_tlast,       // in_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // [7:0] out_byte, [10:8] status,
                                                // [26:11] byte_count, [31:27] zero
    output logic                 m_tuser,       // is_status
    output logic                 m_tlast        // run_last
);

    // Configuration
    logic [COUNT_W-1:0] cap_reg;

    // Input register
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_last_reg;

    // Message state
    logic [2:0]         phase_reg, phase_next;
    logic [6:0]         msb_reg, msb_next;
    logic               dhs_reg, dhs_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic               failed_reg, failed_next;
    status_t            code_reg, code_next;
    logic [6:0]         gbuf_reg [GROUP_LEN];

    // Emit buffer: head at slot 0
    logic [3:0]         cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  ebyte_reg [GROUP_LEN];
    logic               estat_reg;
    status_t            ecode_reg;
    logic [COUNT_W-1:0] ecount_reg;

    logic               emit_data;
    logic               gbuf_wr;
    logic [3:0]         total;
    logic               empty_next;
    logic               advance;
    logic               take;
    logic [COUNT_W:0]   sum_wide;
    logic [BYTE_W-1:0]  rebuilt [GROUP_LEN];
    status_t            st_code;
    logic [COUNT_W-1:0] st_count;

    assign take       = m_tvalid && m_tready;
    assign empty_next = (cnt_reg == 4'd0) || ((cnt_reg == 4'd1) && m_tready);
    assign sum_wide   = {1'b0, done_reg} + {{(COUNT_W-2){1'b0}}, phase_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        msb_next    = msb_reg;
        dhs_next    = dhs_reg;
        done_next   = done_reg;
        failed_next = failed_reg;
        code_next   = code_reg;
        emit_data   = 1'b0;
        gbuf_wr     = 1'b0;

        if (!failed_reg)
        begin
            if (phase_reg == 3'd0)
            begin
                if (in_byte_reg[7])
                begin
                    failed_next = 1'b1;
                    code_next   = ST_HIGH_BIT;
                end
                else if (in_last_reg)
                begin
                    failed_next = 1'b1;
                    code_next   = ST_TRUNC;
                end
                else
                begin
                    msb_next   = in_byte_reg[6:0];
                    dhs_next   = 1'b0;
                    phase_next = 3'd1;
                end
            end
            else
            begin
                gbuf_wr = 1'b1;
                if ((phase_reg == 3'(GROUP_LEN)) || in_last_reg)
                begin
                    // Group closes: checks in fixed priority
                    if ((phase_reg != 3'(GROUP_LEN)) && ((msb_reg >> phase_reg) != 7'd0))
                    begin
                        failed_next = 1'b1;
                        code_next   = ST_BAD_MSB;
                    end
                    else if (sum_wide > {1'b0, cap_reg})
                    begin
                        failed_next = 1'b1;
                        code_next   = ST_NO_ROOM;
                    end
                    else if (dhs_reg || in_byte_reg[7])
                    begin
                        failed_next = 1'b1;
                        code_next   = ST_HIGH_BIT;
                    end
                    else
                    begin
                        emit_data = 1'b1;
                        done_next = sum_wide[COUNT_W-1:0];
                    end
                    phase_next = 3'd0;
                    dhs_next   = 1'b0;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                    dhs_next   = dhs_reg | in_byte_reg[7];
                end
            end
        end

        st_code  = failed_next ? code_next : ST_OK;
        st_count = failed_next ? '0 : done_next;

        if (in_last_reg)
        begin
            phase_next  = 3'd0;
            msb_next    = 7'd0;
            dhs_next    = 1'b0;
            done_next   = '0;
            failed_next = 1'b0;
            code_next   = ST_OK;
        end
    end

    // Rebuild bytes; the closing byte comes straight from the input register
    always_comb
    begin
        for (int j = 0; j < GROUP_LEN; j++)
        begin
            if (3'(j + 1) == phase_reg)
                rebuilt[j] = {msb_reg[j], in_byte_reg[6:0]};
            else
                rebuilt[j] = {msb_reg[j], gbuf_reg[j]};
        end
    end

    assign total = (emit_data ? {1'b0, phase_reg} : 4'd0) + {3'd0, in_last_reg};
    assign advance  = in_valid_reg && ((total == 4'd0) || empty_next);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        cnt_next = cnt_reg;
        if (advance && (total != 4'd0))
            cnt_next = total;
        else if (take)
            cnt_next = cnt_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            in_valid_reg <= 1'b0;
            phase_reg    <= 3'd0;
            msb_reg      <= 7'd0;
            dhs_reg      <= 1'b0;
            done_reg     <= '0;
            failed_reg   <= 1'b0;
            code_reg     <= ST_OK;
            cnt_reg      <= 4'd0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (advance)
            begin
                phase_reg  <= phase_next;
                msb_reg    <= msb_next;
                dhs_reg    <= dhs_next;
                done_reg   <= done_next;
                failed_reg <= failed_next;
                code_reg   <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end

        if (advance && gbuf_wr)
            gbuf_reg[phase_reg - 3'd1] <= in_byte_reg[6:0];

        if (advance && (total != 4'd0))
        begin
            ebyte_reg  <= rebuilt;
            estat_reg  <= in_last_reg;
            ecode_reg  <= st_code;
            ecount_reg <= st_count;
        end
        else if (take)
        begin
            // Shift toward the head
            for (int j = 0; j < GROUP_LEN - 1; j++)
                ebyte_reg[j] <= ebyte_reg[j + 1];
        end
    end

    logic head_is_status;

    assign head_is_status = estat_reg && (cnt_reg == 4'd1);
    assign m_tvalid = (cnt_reg != 4'd0);
    assign m_tuser  = head_is_status;
    assign m_tlast  = (cnt_reg == 4'd1);

    always_comb
    begin
        m_tdata = '0;
        if (head_is_status)
        begin
            m_tdata[M_STAT_MSB:M_STAT_LSB] = ecode_reg;
            m_tdata[M_CNT_MSB:M_CNT_LSB]   = ecount_reg;
        end
        else
        begin
            m_tdata[M_BYTE_LSB +: BYTE_W] = ebyte_reg[0];
        end
    end

endmodule

[rtl/sx7u_checker.sv]
`timescale 1ns / 1ps

module sx7u_checker
    import sx7u_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // A stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed under stall");

    // A status word always ends the run of its input word
    a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status word without tlast");

    // Data words carry no status and no count
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[M_CNT_MSB:M_STAT_LSB] == '0)
        else $error("data word with status fields set");

    // Status words carry a zero byte, and a failed status a zero count
    a_stat_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[M_BYTE_LSB +: BYTE_W] == '0)
        else $error("status word with nonzero byte");

    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && (m_tdata[M_STAT_MSB:M_STAT_LSB] != ST_OK)
            |-> m_tdata[M_CNT_MSB:M_CNT_LSB] == '0)
        else $error("failed status with nonzero count");

endmodule

bind sysex_7bit_unpack_checker_unit sx7u_checker u_sx7u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/tb_sysex_7bit_unpack_checker_unit.sv]
`timescale 1ns / 1ps

module tb_sysex_7bit_unpack_checker_unit;
    import sx7u_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 330;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_WAIT   = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_DIRECTED = 24;

    typedef struct packed {
        logic [7:0]         data;
        logic               is_stat;
        status_t            st;
        logic [COUNT_W-1:0] cnt;
        logic               run_end;
    } unpack_res_t;

    typedef struct packed {
        logic [7:0]         b;
        logic               l;
        logic               typed;
        status_t            st;
        logic [COUNT_W-1:0] cnt;
        logic               wr_cap;
        logic [COUNT_W-1:0] cap;
    } byte_row_t;

    // typed rows carry the status word of the message they close
    localparam byte_row_t BYTE_TABLE [0:NUM_DIRECTED-1] = '{
        '{8'h00, 1'b1, 1'b1, ST_TRUNC,    16'd0, 1'b0, 16'd0},
        '{8'h80, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'hFF, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h34, 1'b1, 1'b1, ST_HIGH_BIT, 16'd0, 1'b0, 16'd0},
        '{8'h7F, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h7F, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h55, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h2A, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h7F, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h01, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h7E, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h7F, 1'b1, 1'b1, ST_OK,       16'd8, 1'b0, 16'd0},
        '{8'h04, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h11, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h22, 1'b1, 1'b1, ST_BAD_MSB,  16'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h81, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h02, 1'b1, 1'b1, ST_HIGH_BIT, 16'd0, 1'b0, 16'd0},
        '{8'h01, 1'b0, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h00, 1'b1, 1'b0, ST_OK,       16'd0, 1'b0, 16'd0},
        '{8'h00, 1'b0, 1'b0, ST_OK,       16'd0, 1'b1, 16'd0},
        '{8'h05, 1'b1, 1'b1, ST_NO_ROOM,  16'd0, 1'b0, 16'd0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // unpacker state mirrored by the predictor
    int                   p_cap;
    int                   p_phase;
    logic [6:0]           p_msb;
    logic [6:0]           p_grp [0:GROUP_LEN-1];
    logic                 p_high;
    int                   p_done;
    logic                 p_failed;
    status_t              p_code;

    unpack_res_t          expected_q [$];

    int                   errors;
    int                   cycles;
    int                   words_sent;
    int                   messages_sent;
    int                   data_seen;
    int                   status_seen;
    int                   caps_written;
    int                   tx_mode;
    int                   rx_mode;
    int                   hold_asked;

    always #5 clk = ~clk;

    sysex_7bit_unpack_checker_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    function automatic void clear_message();
        p_phase  = 0;
        p_msb    = '0;
        p_high   = 1'b0;
        p_done   = 0;
        p_failed = 1'b0;
        p_code   = ST_OK;
    endfunction

    // Work out the result words that one accepted packed word causes.
    function automatic void unpack_word(input logic [7:0] b, input logic l);
        int k;
        if (!p_failed) begin
            if (p_phase == 0) begin
                if (b[7]) begin
                    p_failed = 1'b1;
                    p_code   = ST_HIGH_BIT;
                end
                else if (l) begin
                    p_failed = 1'b1;
                    p_code   = ST_TRUNC;
                end
                else begin
                    p_msb   = b[6:0];
                    p_high  = 1'b0;
                    p_phase = 1;
                end
            end
            else begin
                p_grp[p_phase-1] = b[6:0];
                if (b[7])
                    p_high = 1'b1;
                k = p_phase;
                if (k >= GROUP_LEN || l) begin
                    if (k < GROUP_LEN && (p_msb >> k) != 0) begin
                        p_failed = 1'b1;
                        p_code   = ST_BAD_MSB;
                    end
                    else if (p_done + k > p_cap) begin
                        p_failed = 1'b1;
                        p_code   = ST_NO_ROOM;
                    end
                    else if (p_high) begin
                        p_failed = 1'b1;
                        p_code   = ST_HIGH_BIT;
                    end
                    else begin
                        for (int j = 0; j < k; j++)
                            expected_q.push_back('{{p_msb[j], p_grp[j]}, 1'b0, ST_OK,
                                                   16'd0, !l && (j == k - 1)});
                        p_done = p_done + k;
                    end
                    p_phase = 0;
                    p_high  = 1'b0;
                end
                else begin
                    p_phase = k + 1;
                end
            end
        end
        if (l) begin
            if (p_failed)
                expected_q.push_back('{8'h00, 1'b1, p_code, 16'd0, 1'b1});
            else
                expected_q.push_back('{8'h00, 1'b1, ST_OK, p_done[15:0], 1'b1});
            clear_message();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one packed word and return at the edge it is taken.
    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        if (l)
            messages_sent++;
        unpack_word(b, l);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [COUNT_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        p_cap = int'(v);
        caps_written++;
    endtask

    // Build one message: mostly well-formed groups, some broken on purpose.
    task automatic send_message();
        logic [7:0] msg [$];
        logic [7:0] m;
        int         kind;
        int         n;
        int         idx;
        int         k;
        int         msb_pos;
        int         cut;
        kind    = $urandom_range(0, 99);
        n       = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
        idx     = 0;
        k       = 0;
        msb_pos = 0;
        if (kind >= 70 && kind < 76)
            n = GROUP_LEN * $urandom_range(0, 2);
        while (idx < n) begin
            k = (n - idx >= GROUP_LEN) ? GROUP_LEN : n - idx;
            m = 8'($urandom_range(0, 127));
            if (k < GROUP_LEN)
                m = m & ((8'h01 << k) - 8'h01);
            msb_pos = msg.size();
            msg.push_back(m);
            repeat (k) msg.push_back(8'($urandom_range(0, 127)));
            idx += k;
        end
        if (kind < 62) begin
            // keep it clean
        end
        else if (kind < 70) begin
            idx = $urandom_range(0, msg.size() - 1);
            msg[idx] = msg[idx] | 8'h80;
        end
        else if (kind < 76) begin
            // end on an MSB byte
            msg.push_back(8'($urandom_range(0, 127)));
        end
        else if (kind < 84) begin
            if (k < GROUP_LEN)
                msg[msb_pos] = msg[msb_pos] | (8'h01 << $urandom_range(k, GROUP_LEN - 1));
            else
                msg[msb_pos] = msg[msb_pos] | 8'h80;
        end
        else if (kind < 92) begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut)
                void'(msg.pop_back());
        end
        else begin
            msg.delete();
            repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < msg.size(); i++)
            send_word(msg[i], i == msg.size() - 1);
    endtask

    // receiver side: random stalls, plus a long hold-off on request
    always @(posedge clk) begin : receiver
        int stall_left;
        int hold_left;
        int hold_done;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else begin
            m_tready <= 1'b1;
            if (rx_mode != 0 && $urandom_range(0, 99) < 30)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk) begin : result_check
        unpack_res_t got;
        unpack_res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[M_BYTE_LSB +: BYTE_W], m_tuser,
                    status_t'(m_tdata[M_STAT_MSB:M_STAT_LSB]),
                    m_tdata[M_CNT_MSB:M_CNT_LSB], m_tlast};
            if (got.is_stat)
                status_seen++;
            else
                data_seen++;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: out_byte %0h is_status %0b",
                       got.data, got.is_stat);
                errors++;
            end
            else begin
                want = expected_q.pop_front();
                if (got.data !== want.data) begin
                    $error("out_byte: expected %0h, got %0h", want.data, got.data);
                    errors++;
                end
                if (got.is_stat !== want.is_stat) begin
                    $error("is_status: expected %0b, got %0b", want.is_stat, got.is_stat);
                    errors++;
                end
                if (got.st !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    errors++;
                end
                if (got.cnt !== want.cnt) begin
                    $error("byte_count: expected %0d, got %0d", want.cnt, got.cnt);
                    errors++;
                end
                if (got.run_end !== want.run_end) begin
                    $error("run_last: expected %0b, got %0b", want.run_end, got.run_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sysex_7bit_unpack_checker_unit test failed");
            $finish;
        end
    end

    initial begin
        int          target;
        logic [15:0] cap_pick;
        errors        = 0;
        cycles        = 0;
        words_sent    = 0;
        messages_sent = 0;
        data_seen     = 0;
        status_seen   = 0;
        caps_written  = 0;
        hold_asked    = 0;
        tx_mode       = 0;
        rx_mode       = 0;
        p_cap         = int'(CAP_RESET);
        for (int i = 0; i < GROUP_LEN; i++)
            p_grp[i] = '0;
        clear_message();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (BYTE_TABLE[i].wr_cap)
                set_capacity(BYTE_TABLE[i].cap);
            send_word(BYTE_TABLE[i].b, BYTE_TABLE[i].l);
            // swap in the hand-written status word for this message
            if (BYTE_TABLE[i].typed)
                expected_q[expected_q.size() - 1] = '{8'h00, 1'b1, BYTE_TABLE[i].st,
                                                      BYTE_TABLE[i].cnt, 1'b1};
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0, 6:    cap_pick = 16'hFFFF;
                1:       cap_pick = 16'($urandom_range(5, 30));
                2:       cap_pick = 16'h0000;
                4:       cap_pick = 16'(GROUP_LEN);
                5:       cap_pick = 16'($urandom_range(10, 60));
                7:       cap_pick = 16'($urandom_range(20, 200));
                default: cap_pick = 16'($urandom_range(0, 65535));
            endcase
            set_capacity(cap_pick);
            tx_mode = ph % 3;
            rx_mode = (ph % 4 != 0) ? 1 : 0;
            // stall the output for a long stretch while words keep coming
            if (ph == 0 || ph == 6)
                hold_asked++;
            target = NUM_DIRECTED + (ph + 1) * RANDOM_WORDS / NUM_PHASES;
            while (words_sent < target)
                send_message();
        end

        wait_drained();
        $display("Sent %0d packed words in %0d messages over %0d capacity settings;",
                 words_sent, messages_sent, caps_written);
        $display("checked %0d data words and %0d status words.", data_seen, status_seen);
        if (errors == 0)
            $display("sysex_7bit_unpack_checker_unit test passed");
        else
            $display("sysex_7bit_unpack_checker_unit test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/sx7u_pkg.sv
rtl/sysex_7bit_unpack_checker_unit.sv
rtl/sx7u_checker.sv
bench/tb_sysex_7bit_unpack_checker_unit.sv
